// ===== rtl/core/lcg_rng_pkg.sv =====
// Shared types and constants for the range-limited LCG random generator.
`timescale 1ns / 1ps

package lcg_rng_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned DRAW_W    = 15;
   localparam int unsigned DRAW_LSB  = 16;
   localparam int unsigned DIGIT_W   = 2;
   localparam int unsigned MUL_STEPS = WORD_W / DIGIT_W;
   localparam int unsigned DIV_STEPS = DRAW_W;
   localparam int unsigned CNT_W     = 4;

   localparam logic [WORD_W-1:0] LCG_MUL   = 32'd1103515245;
   localparam logic [WORD_W-1:0] LCG_MUL3  = 32'(34'(LCG_MUL) * 34'd3);
   localparam logic [WORD_W-1:0] LCG_INC   = 32'd12345;
   localparam logic [WORD_W-1:0] SEED_INIT = 32'd1;

   localparam logic OP_RESEED = 1'b0;
   localparam logic OP_DRAW   = 1'b1;

   localparam logic [DIGIT_W-1:0] DIG_ZERO  = 2'd0;
   localparam logic [DIGIT_W-1:0] DIG_ONE   = 2'd1;
   localparam logic [DIGIT_W-1:0] DIG_TWO   = 2'd2;
   localparam logic [DIGIT_W-1:0] DIG_THREE = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_ADD
   } state_type;

endpackage

// ===== rtl/core/lcg_rng_if.sv =====
// Valid/ready channel interfaces for the request and response words.
`timescale 1ns / 1ps

interface lcg_req_if import lcg_rng_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic        [WORD_W-1:0] seed_value;
   logic signed [WORD_W-1:0] range_low;
   logic signed [WORD_W-1:0] range_high;

   modport source (output valid, operation, seed_value, range_low, range_high,
                   input ready);
   modport sink (input valid, operation, seed_value, range_low, range_high,
                 output ready);
endinterface

interface lcg_rsp_if import lcg_rng_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] random_value;

   modport source (output valid, random_value, input ready);
   modport sink (input valid, random_value, output ready);
endinterface

// ===== rtl/core/lcg_random_in_range.sv =====
// Range-limited random generator on a 32-bit linear congruential state.
//
// Request channel req_chan carries one word: operation, seed_value,
// range_low, range_high. A reseed word loads the state from a nonzero seed
// and gives no response. A draw word gives one response word on rsp_chan
// holding random_value in [range_low, range_high), or range_low when the
// range is empty.
// A draw advances the state with a radix-4 shift-add multiply, reduces
// state bits 30..16 modulo the span with a radix-2 restoring remainder,
// then adds range_low into the response register. An empty range skips
// the multiply and remainder, with the state untouched. One word is in work
// at a time; req_chan is ready only while idle, so the next word is not
// taken until the current one has finished.
// The response register holds its word while rsp_chan is stalled; a draw
// that finishes meanwhile waits in its final step until the register frees.
// Reset (synchronous) sets the state to 1 and empties the response register.
`timescale 1ns / 1ps

module lcg_random_in_range import lcg_rng_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lcg_req_if.sink    req_chan,
   lcg_rsp_if.source  rsp_chan
);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [WORD_W-1:0]        gen_ff, gen_in;
   logic [WORD_W-1:0]        mplier_ff, mplier_in;
   logic [WORD_W-1:0]        mc1_ff, mc1_in;
   logic [WORD_W-1:0]        mc3_ff, mc3_in;
   logic [WORD_W-1:0]        acc_ff, acc_in;
   logic [WORD_W-1:0]        span_ff, span_in;
   logic [WORD_W-1:0]        low_ff, low_in;
   logic [DRAW_W-1:0]        dq_ff, dq_in;
   logic [DRAW_W-1:0]        rem_ff, rem_in;
   logic                     out_vld_ff, out_vld_in;
   logic [WORD_W-1:0]        out_dat_ff, out_dat_in;

   logic                     req_fire;
   logic                     empty_rng;
   logic [WORD_W-1:0]        addend;
   logic [WORD_W-1:0]        acc_sum;
   logic [DRAW_W:0]          trial;
   logic                     trial_ge;
   logic                     out_free;

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign req_fire            = req_chan.valid && req_chan.ready;
   assign empty_rng           = (req_chan.range_high <= req_chan.range_low);
   assign out_free            = !out_vld_ff || rsp_chan.ready;
   assign rsp_chan.valid      = out_vld_ff;
   assign rsp_chan.random_value = out_dat_ff;

   always_comb begin
      case (mplier_ff[DIGIT_W-1:0])
         DIG_ZERO:  addend = '0;
         DIG_ONE:   addend = mc1_ff;
         DIG_TWO:   addend = {mc1_ff[WORD_W-2:0], 1'b0};
         DIG_THREE: addend = mc3_ff;
         default:   addend = '0;
      endcase
   end

   assign acc_sum  = acc_ff + addend;
   assign trial    = {rem_ff, dq_ff[DRAW_W-1]};
   assign trial_ge = ({{(WORD_W-DRAW_W-1){1'b0}}, trial} >= span_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_chan.operation == OP_DRAW) begin
               state_in = empty_rng ? ST_ADD : ST_MUL;
            end
         end
         ST_MUL: begin
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = ST_ADD;
         end
         ST_ADD: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      cnt_in     = cnt_ff;
      gen_in     = gen_ff;
      mplier_in  = mplier_ff;
      mc1_in     = mc1_ff;
      mc3_in     = mc3_ff;
      acc_in     = acc_ff;
      span_in    = span_ff;
      low_in     = low_ff;
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      out_dat_in = out_dat_ff;
      out_vld_in = out_vld_ff && !rsp_chan.ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.operation == OP_RESEED) begin
                  if (req_chan.seed_value != '0) gen_in = req_chan.seed_value;
               end else begin
                  low_in    = req_chan.range_low;
                  span_in   = WORD_W'({req_chan.range_high[WORD_W-1], req_chan.range_high}
                                    - {req_chan.range_low[WORD_W-1], req_chan.range_low});
                  rem_in    = '0;
                  mplier_in = gen_ff;
                  mc1_in    = LCG_MUL;
                  mc3_in    = LCG_MUL3;
                  acc_in    = LCG_INC;
                  cnt_in    = '0;
               end
            end
         end
         ST_MUL: begin
            acc_in    = acc_sum;
            mplier_in = {{DIGIT_W{1'b0}}, mplier_ff[WORD_W-1:DIGIT_W]};
            mc1_in    = {mc1_ff[WORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            mc3_in    = {mc3_ff[WORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               gen_in = acc_sum;
               dq_in  = acc_sum[DRAW_LSB +: DRAW_W];
               rem_in = '0;
               cnt_in = '0;
            end
         end
         ST_DIV: begin
            rem_in = trial_ge ? DRAW_W'(trial - span_ff[DRAW_W:0]) : DRAW_W'(trial);
            dq_in  = {dq_ff[DRAW_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
         ST_ADD: begin
            if (out_free) begin
               out_dat_in = low_ff + {{(WORD_W-DRAW_W){1'b0}}, rem_ff};
               out_vld_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         gen_ff     <= SEED_INIT;
         out_vld_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         gen_ff     <= gen_in;
         out_vld_ff <= out_vld_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mplier_ff  <= mplier_in;
      mc1_ff     <= mc1_in;
      mc3_ff     <= mc3_in;
      acc_ff     <= acc_in;
      span_ff    <= span_in;
      low_ff     <= low_in;
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      out_dat_ff <= out_dat_in;
   end

endmodule
